// ===== hdl/ykd_pkg.sv =====
package ykd_pkg;

	// Register file
	localparam int CFG_W   = 32;
	localparam int SR_W    = 14;
	localparam int NOISE_W = 32;
	localparam int IDX_W   = 3;

	// Gain divider and shared multiplier
	localparam int FRAC_W = 24;
	localparam int GAIN_W = FRAC_W + 1;
	localparam int DEN_W  = NOISE_W + 1;
	localparam int REM_W  = NOISE_W + 2;
	localparam int MAC_W  = 25;
	localparam int ACC_W  = 3 * MAC_W;

	localparam logic [GAIN_W-1:0] ONE_GAIN = 25'h100_0000;

	// Register reset values
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 32'd167772;
	localparam logic [NOISE_W-1:0] PROC_NOISE_RST = 32'd168;
	localparam logic [CFG_W-1:0]   INIT_EST_RST   = 32'd0;
	localparam logic [NOISE_W-1:0] INIT_COV_RST   = 32'd16777216;
	localparam logic [SR_W-1:0]    SAMPLE_RATE_RST = 14'd100;

	typedef enum logic [IDX_W-1:0] {
		REG_MEAS_NOISE    = 3'd0,
		REG_PROCESS_NOISE = 3'd1,
		REG_INIT_ESTIMATE = 3'd2,
		REG_INIT_COV      = 3'd3,
		REG_SAMPLE_RATE   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_DSTART,
		ST_DIV,
		ST_DIFF,
		ST_EST_LO,
		ST_EST_HI,
		ST_EST_UPD,
		ST_COV_LO,
		ST_COV_HI,
		ST_COV_UPD,
		ST_ACC_LO,
		ST_ACC_HI,
		ST_ACC_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic hi;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/ykd_div.sv =====
module ykd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ykd_pkg::NOISE_W-1:0]   num,
	input  logic [ykd_pkg::NOISE_W-1:0]   noise,
	output logic [ykd_pkg::GAIN_W-1:0]    quot,
	output ykd_pkg::div_stat_t            stat
);
	import ykd_pkg::*;

	localparam int CNT_W = $clog2(GAIN_W + 1);

	logic [DEN_W-1:0]  den_in;
	logic [DEN_W-1:0]  den_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  trial;
	logic [GAIN_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	// Denominator is predicted covariance plus measurement noise
	assign den_in = DEN_W'(num) + DEN_W'(noise);

	// One restoring step: compare, subtract if it fits
	assign fits  = rem_q >= REM_W'(den_q);
	assign trial = fits ? (rem_q - REM_W'(den_q)) : rem_q;

	// Sequence control; a zero denominator finishes at once with zero gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (den_in == '0) ? '0 : CNT_W'(GAIN_W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den_in;
			rem_q  <= REM_W'(num);
			quot_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q  <= {trial[REM_W-2:0], 1'b0};
			quot_q <= {quot_q[GAIN_W-2:0], fits};
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/ykd_mac.sv =====
module ykd_mac (
	input  logic                        clk,
	input  ykd_pkg::mac_ctl_t           ctl,
	input  logic [ykd_pkg::MAC_W-1:0]   a,
	input  logic [ykd_pkg::MAC_W-1:0]   b,
	output logic [ykd_pkg::ACC_W-1:0]   acc
);
	import ykd_pkg::*;

	logic [2*MAC_W-1:0] prod;
	logic [ACC_W-1:0]   addend;
	logic [ACC_W-1:0]   base;
	logic [ACC_W-1:0]   acc_q;

	// Partial product, placed at the low or the high chunk position
	assign prod   = a * b;
	assign addend = ctl.hi ? {prod, {MAC_W{1'b0}}} : ACC_W'(prod);
	assign base   = ctl.clr ? '0 : acc_q;

	// Accumulate one partial product per pass
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hdl/yaw_rate_kalman_differentiator.sv =====
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tdata: angular_rate_z
// m_*       out        m_tvalid/m_tready   tdata: raw_rate, filtered_rate, yaw_accel;
//                                          tuser: filtered_valid
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A filter sample raises m_tvalid with s_tready back high; the gain divider works first
// (start, 25 steps, finish) and six passes of the shared 25x25 multiplier follow.
// The priming sample after reset skips the divider and multiplier and goes straight to its result.
// Reset clears the sequencer, the output valid and loads the register defaults.
// The next word is accepted while a finished result still waits on m_tready;
// the result stage holds until the output register is free.
module yaw_rate_kalman_differentiator #(
	parameter int RATE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// [RATE_WIDTH-1:0] angular_rate_z
	input  logic [((RATE_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// raw_rate, filtered_rate, yaw_accel, each RATE_WIDTH bits, lowest first
	output logic [((3*RATE_WIDTH+7)/8)*8-1:0]      m_tdata,
	// [0] filtered_valid
	output logic [0:0]                             m_tuser,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ykd_pkg::IDX_W-1:0]              cfg_index,
	input  logic [ykd_pkg::CFG_W-1:0]              cfg_data
);
	import ykd_pkg::*;

	localparam int RW     = RATE_WIDTH;
	localparam int MAG_W  = RW + 1;
	localparam int EW     = (RW > CFG_W) ? RW : CFG_W;
	localparam int OUT_TW = ((3*RW+7)/8)*8;

	localparam logic [RW-1:0] RMAX = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0] RMIN = ~RMAX;
	localparam logic signed [EW-1:0] RMAX_E = EW'(RMAX);
	localparam logic signed [EW-1:0] RMIN_E = ~RMAX_E;

	// Configuration registers
	logic [NOISE_W-1:0] meas_q;
	logic [NOISE_W-1:0] proc_q;
	logic [CFG_W-1:0]   iest_q;
	logic [NOISE_W-1:0] icov_q;
	logic [SR_W-1:0]    srate_q;

	// Sequencer and filter state
	state_t             state_q;
	state_t             state_d;
	logic               first_q;
	logic [RW-1:0]      last_q;
	logic [RW-1:0]      est_q;
	logic [NOISE_W-1:0] cov_q;
	logic [RW-1:0]      z_q;
	logic [NOISE_W-1:0] pp_q;
	logic [GAIN_W-1:0]  k_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [RW-1:0]      filt_q;
	logic [RW-1:0]      accel_q;
	logic               flag_q;

	// Output register
	logic               m_tvalid_q;
	logic [OUT_TW-1:0]  m_tdata_q;
	logic               m_tuser_q;

	// Datapath signals
	logic                accept;
	logic                out_free;
	logic [RW-1:0]       in_rate;
	logic                in_min;
	logic [RW-1:0]       z_in;
	logic signed [EW-1:0] ie_ext;
	logic [RW-1:0]       est_init;
	logic [NOISE_W:0]    cov_sum;
	logic [NOISE_W-1:0]  pp_next;
	logic [RW-1:0]       dif_a;
	logic [RW-1:0]       dif_b;
	logic [MAG_W-1:0]    dif;
	logic [MAG_W-1:0]    dif_mag;
	logic [2*MAC_W-1:0]  mag_ext;
	logic [MAG_W-1:0]    step_r;
	logic [RW+1:0]       step_s;
	logic [RW+1:0]       est_sum;
	logic                sat_pos;
	logic                sat_neg;
	logic [RW-1:0]       accel_next;
	logic [GAIN_W-1:0]   one_minus_k;

	// Shared unit control
	logic                div_start;
	logic [GAIN_W-1:0]   div_quot;
	div_stat_t           div_stat;
	mac_ctl_t            mac_ctl;
	logic [MAC_W-1:0]    mac_a;
	logic [MAC_W-1:0]    mac_b;
	logic [ACC_W-1:0]    mac_acc;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// Negate the incoming rate, saturating the most negative code
	assign in_rate = s_tdata[RW-1:0];
	assign in_min  = in_rate[RW-1] && !(|in_rate[RW-2:0]);
	assign z_in    = in_min ? RMAX : (~in_rate + 1'b1);

	// Clamp the starting estimate to the rate range
	assign ie_ext   = EW'($signed(iest_q));
	assign est_init = (ie_ext > RMAX_E) ? RMAX :
	                  (ie_ext < RMIN_E) ? RMIN : ie_ext[RW-1:0];

	// Predicted covariance, saturating
	assign cov_sum = {1'b0, cov_q} + {1'b0, proc_q};
	assign pp_next = cov_sum[NOISE_W] ? '1 : cov_sum[NOISE_W-1:0];

	// Shared subtractor: innovation first, then rate difference
	assign dif_a   = (state_q == ST_DIFF) ? z_q : est_q;
	assign dif_b   = (state_q == ST_DIFF) ? est_q : last_q;
	assign dif     = {dif_a[RW-1], dif_a} - {dif_b[RW-1], dif_b};
	assign dif_mag = dif[MAG_W-1] ? (~dif + 1'b1) : dif;
	assign mag_ext = (2*MAC_W)'(mag_q);

	// Estimate update: step is truncated toward zero
	assign step_r  = mac_acc[FRAC_W +: MAG_W];
	assign step_s  = neg_q ? ((RW+2)'(0) - (RW+2)'(step_r)) : (RW+2)'(step_r);
	assign est_sum = {{2{est_q[RW-1]}}, est_q} + step_s;

	// Acceleration saturation
	assign sat_pos    = |mac_acc[ACC_W-1:RW-1];
	assign sat_neg    = (|mac_acc[ACC_W-1:RW]) || (mac_acc[RW-1] && (|mac_acc[RW-2:0]));
	assign accel_next = neg_q ? (sat_neg ? RMIN : (~mac_acc[RW-1:0] + 1'b1)) :
	                            (sat_pos ? RMAX : mac_acc[RW-1:0]);

	assign one_minus_k = ONE_GAIN - k_q;

	ykd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (pp_q),
		.noise  (meas_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	ykd_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (mac_acc)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q  <= MEAS_NOISE_RST;
			proc_q  <= PROC_NOISE_RST;
			iest_q  <= INIT_EST_RST;
			icov_q  <= INIT_COV_RST;
			srate_q <= SAMPLE_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MEAS_NOISE:    meas_q  <= cfg_data;
				REG_PROCESS_NOISE: proc_q  <= cfg_data;
				REG_INIT_ESTIMATE: iest_q  <= cfg_data;
				REG_INIT_COV:      icov_q  <= cfg_data;
				REG_SAMPLE_RATE:   srate_q <= cfg_data[SR_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept) state_d = first_q ? ST_DONE : ST_PRED;
			ST_PRED:    state_d = ST_DSTART;
			ST_DSTART:  state_d = ST_DIV;
			ST_DIV:     if (div_stat.done) state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_EST_LO;
			ST_EST_LO:  state_d = ST_EST_HI;
			ST_EST_HI:  state_d = ST_EST_UPD;
			ST_EST_UPD: state_d = ST_COV_LO;
			ST_COV_LO:  state_d = ST_COV_HI;
			ST_COV_HI:  state_d = ST_COV_UPD;
			ST_COV_UPD: state_d = ST_ACC_LO;
			ST_ACC_LO:  state_d = ST_ACC_HI;
			ST_ACC_HI:  state_d = ST_ACC_UPD;
			ST_ACC_UPD: state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider start, multiplier passes
	always_comb begin
		s_tready    = 1'b0;
		div_start   = 1'b0;
		mac_ctl     = '0;
		mac_a       = '0;
		mac_b       = '0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_EST_LO: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
				mac_a   = mag_ext[MAC_W-1:0];
				mac_b   = k_q;
			end
			ST_EST_HI: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
				mac_a   = mag_ext[2*MAC_W-1:MAC_W];
				mac_b   = k_q;
			end
			ST_COV_LO: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
				mac_a   = one_minus_k;
				mac_b   = pp_q[MAC_W-1:0];
			end
			ST_COV_HI: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
				mac_a   = one_minus_k;
				mac_b   = MAC_W'(pp_q[NOISE_W-1:MAC_W]);
			end
			ST_ACC_LO: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
				mac_a   = mag_ext[MAC_W-1:0];
				mac_b   = MAC_W'(srate_q);
			end
			ST_ACC_HI: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
				mac_a   = mag_ext[2*MAC_W-1:MAC_W];
				mac_b   = MAC_W'(srate_q);
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			first_q    <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && first_q) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Filter state; covariance and estimate start at zero until primed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			est_q  <= '0;
			cov_q  <= '0;
		end else begin
			if (accept && first_q) begin
				last_q <= z_in;
				est_q  <= est_init;
				cov_q  <= icov_q;
			end
			if (state_q == ST_EST_UPD) begin
				est_q <= est_sum[RW-1:0];
			end
			if (state_q == ST_COV_UPD) begin
				cov_q <= mac_acc[FRAC_W +: NOISE_W];
			end
			if (state_q == ST_ACC_UPD) begin
				last_q <= est_q;
			end
		end
	end

	// Working registers of one sample
	always_ff @(posedge clk) begin
		if (accept) begin
			z_q     <= z_in;
			filt_q  <= '0;
			accel_q <= '0;
			flag_q  <= 1'b0;
		end
		if (state_q == ST_PRED) begin
			pp_q <= pp_next;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			k_q <= div_quot;
		end
		if (state_q == ST_DIFF || state_q == ST_COV_UPD) begin
			mag_q <= dif_mag;
			neg_q <= dif[MAG_W-1];
		end
		if (state_q == ST_ACC_UPD) begin
			accel_q <= accel_next;
			filt_q  <= est_q;
			flag_q  <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= OUT_TW'({accel_q, filt_q, z_q});
			m_tuser_q <= flag_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// Input is never taken while the divider is still iterating
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_stat.busy)
		else $error("input accepted while gain divider busy");

	// Divider completion is only seen while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("gain divider finished outside wait state");

	// Priming flag clears only on an accepted sample
	a_prime_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(s_tvalid && s_tready))
		else $error("priming flag cleared without an input word");

	// A finished sample always reaches the output register
	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("result not loaded into output register");

endmodule

// ===== tb/tb_yaw_rate_kalman_differentiator.sv =====
module tb_yaw_rate_kalman_differentiator;
	timeunit 1ns;
	timeprecision 1ps;

	import ykd_pkg::*;

	localparam int          RW          = 32;
	localparam longint      RATE_MAX    = 64'sd2147483647;
	localparam longint      RATE_MIN    = -64'sd2147483648;
	localparam longint      GAIN_UNITY  = 64'sd1 << FRAC_W;
	localparam int          PHASES      = 13;
	localparam int          PHASE_WORDS = 150;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 80;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic {ROW_CFG, ROW_RATE} row_kind_t;

	typedef struct packed {
		logic [RW-1:0] raw;
		logic [RW-1:0] filt;
		logic [RW-1:0] accel;
		logic          valid;
	} rate_result_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [31:0]      data;
		logic             typed;
		rate_result_t     want;
	} plan_row_t;

	localparam int PLAN_ROWS = 34;

	// Directed walk: extremes of the rate, priming, saturation, zero rate,
	// zero noise with zero covariance, saturated noise, ignored index.
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_CFG,  REG_INIT_ESTIMATE, 32'h8000_0000, 1'b0, '0},
		'{ROW_CFG,  REG_INIT_COV,      32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_CFG,  REG_SAMPLE_RATE,   32'h0000_3FFF, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h8000_0000, 1'b1,
			'{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0}},
		'{ROW_RATE, 3'd0, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h8000_0001, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0000_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0000_0001, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0001_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hFFFF_0000, 1'b0, '0},
		'{ROW_CFG,  REG_SAMPLE_RATE,   32'h0000_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h1234_5678, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hEDCB_A988, 1'b0, '0},
		'{ROW_CFG,  REG_MEAS_NOISE,    32'h0000_0000, 1'b0, '0},
		'{ROW_CFG,  REG_PROCESS_NOISE, 32'h0000_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0050_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hFFB0_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0003_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h7FFF_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h8000_0000, 1'b0, '0},
		'{ROW_CFG,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_CFG,  REG_MEAS_NOISE,    32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_CFG,  REG_SAMPLE_RATE,   32'd10000,     1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h4000_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hC000_0000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h00AB_CDEF, 1'b0, '0},
		'{ROW_CFG,  REG_SPARE,         32'hDEAD_BEEF, 1'b0, '0},
		'{ROW_CFG,  REG_MEAS_NOISE,    32'h0000_0001, 1'b0, '0},
		'{ROW_CFG,  REG_PROCESS_NOISE, 32'd168,       1'b0, '0},
		'{ROW_CFG,  REG_SAMPLE_RATE,   32'h0000_0001, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'h0000_8000, 1'b0, '0},
		'{ROW_RATE, 3'd0, 32'hFFFF_8000, 1'b0, '0}
	};

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [RW-1:0]          s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [3*RW-1:0]        m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	// Filter copy: registers and state
	logic [NOISE_W-1:0] noise_r  = MEAS_NOISE_RST;
	logic [NOISE_W-1:0] noise_q  = PROC_NOISE_RST;
	logic [CFG_W-1:0]   x0_reg   = INIT_EST_RST;
	logic [NOISE_W-1:0] p0_reg   = INIT_COV_RST;
	logic [SR_W-1:0]    fs_reg   = SAMPLE_RATE_RST;
	bit                 first_due = 1'b1;
	longint             last_rate_q;
	longint             est_q;
	logic [NOISE_W-1:0] cov_q;

	rate_result_t pending_results [$];
	int           mismatches = 0;
	int           drift = 0;
	bit           tx_busy = 1'b0;
	bit           rx_free = 1'b0;
	bit           hold_req = 1'b0;

	yaw_rate_kalman_differentiator #(.RATE_WIDTH(RW)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mirror one register write
	function automatic void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_MEAS_NOISE: begin
				noise_r = data;
			end
			REG_PROCESS_NOISE: begin
				noise_q = data;
			end
			REG_INIT_ESTIMATE: begin
				x0_reg = data;
			end
			REG_INIT_COV: begin
				p0_reg = data;
			end
			REG_SAMPLE_RATE: begin
				fs_reg = data[SR_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the filter by one gyro word and return the expected output word
	function automatic rate_result_t filter_sample(logic [RW-1:0] rate_in);
		rate_result_t res;
		longint z, pp, den, gain, diff, mag, step, prod, acc;
		res = '0;
		z = -longint'($signed(rate_in));
		if (z > RATE_MAX) z = RATE_MAX;
		res.raw = z[RW-1:0];
		if (first_due) begin
			// prime: hold the rate, load estimate and covariance
			first_due = 1'b0;
			last_rate_q = z;
			est_q = longint'($signed(x0_reg));
			cov_q = p0_reg;
		end else begin
			pp = {32'd0, cov_q} + {32'd0, noise_q};
			if (pp > 64'sh0_FFFF_FFFF) pp = 64'sh0_FFFF_FFFF;
			den = pp + {32'd0, noise_r};
			gain = (den == 0) ? 64'sd0 : (pp << FRAC_W) / den;
			// estimate moves toward z, product truncated toward zero
			diff = z - est_q;
			mag = (diff < 0) ? -diff : diff;
			step = (mag >> FRAC_W) * gain + (((mag & 64'sh00FF_FFFF) * gain) >> FRAC_W);
			est_q = est_q + ((diff < 0) ? -step : step);
			cov_q = 32'(((GAIN_UNITY - gain) * pp) >> FRAC_W);
			// acceleration with saturation
			diff = est_q - last_rate_q;
			mag = (diff < 0) ? -diff : diff;
			prod = mag * longint'({50'd0, fs_reg});
			if (diff < 0)
				acc = (prod > -RATE_MIN) ? RATE_MIN : -prod;
			else
				acc = (prod > RATE_MAX) ? RATE_MAX : prod;
			last_rate_q = est_q;
			res.filt = est_q[RW-1:0];
			res.accel = acc[RW-1:0];
			res.valid = 1'b1;
		end
		return res;
	endfunction

	// Idle cycles before the next word: mostly none, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_busy || r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 45);
		return $urandom_range(46, 120);
	endfunction

	// Gyro word: mostly a drifting level with noise, some wild values
	function automatic logic [RW-1:0] next_rate();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			drift = drift + int'($urandom_range(0, 131072)) - 65536;
			if (drift > 32'sh1000_0000 || drift < -32'sh1000_0000) drift = drift / 2;
			return drift + int'($urandom_range(0, 262144)) - 131072;
		end
		if (r < 85) return $urandom;
		if (r < 93) begin
			drift = int'($urandom) >>> 4;
			return drift;
		end
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0001;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg_value(logic [IDX_W-1:0] idx);
		case (idx)
			REG_MEAS_NOISE: begin
				case ($urandom_range(0, 5))
					0: return 32'h1;
					1: return 32'hFFFF_FFFF;
					2: return $urandom;
					default: return $urandom_range(1000, 4_000_000);
				endcase
			end
			REG_PROCESS_NOISE: begin
				case ($urandom_range(0, 5))
					0: return 32'h0;
					1: return 32'hFFFF_FFFF;
					2: return $urandom;
					default: return $urandom_range(0, 200_000);
				endcase
			end
			REG_SAMPLE_RATE: begin
				case ($urandom_range(0, 5))
					0: return 32'd1;
					1: return 32'd10000;
					default: return $urandom_range(1, 10000);
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Offer one gyro word, hold it until accepted, then queue its output
	task automatic push_rate(logic [RW-1:0] v, bit typed, rate_result_t want);
		int unsigned g;
		rate_result_t res;
		g = pick_gap();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = filter_sample(v);
		pending_results.insert(pending_results.size(), typed ? want : res);
	endtask

	// Drop input valid and wait until every queued output has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		set_register(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Output side: random stalls, free-running stretches, two long hold-offs
	initial begin
		int unsigned stall;
		int unsigned r;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_free) begin
				m_tready <= 1'b1;
			end else if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (r < 70) begin
				m_tready <= 1'b1;
			end else if (r < 95) begin
				stall = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				stall = $urandom_range(10, 60);
				m_tready <= 1'b0;
			end
		end
	end

	function automatic void report_field(string name, logic [RW-1:0] want, logic [RW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each output word with the oldest queued one
	always @(posedge clk) begin
		rate_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected output word, expected none, got %h/%b",
					$realtime, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				report_field("raw_rate", want.raw, m_tdata[RW-1:0]);
				report_field("filtered_rate", want.filt, m_tdata[2*RW-1:RW]);
				report_field("yaw_accel", want.accel, m_tdata[3*RW-1:2*RW]);
				report_field("filtered_valid", {31'd0, want.valid}, {31'd0, m_tuser[0]});
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].data);
			else
				push_rate(plan[i].data, plan[i].typed, plan[i].want);
		end

		// random phases, new register settings between them
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int k = 0; k <= int'(REG_SAMPLE_RATE); k++) begin
				if ($urandom_range(0, 1))
					write_reg(k[IDX_W-1:0], pick_reg_value(k[IDX_W-1:0]));
			end
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_SPARE, $urandom);
			tx_busy = (ph % 4 == 1);
			rx_free = (ph % 4 == 2);
			if (ph == 3 || ph == 9) hold_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++)
				push_rate(next_rate(), 1'b0, '0);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ykd_pkg.sv
hdl/ykd_div.sv
hdl/ykd_mac.sv
hdl/yaw_rate_kalman_differentiator.sv
tb/tb_yaw_rate_kalman_differentiator.sv
